FILE: rtl/core/pfi_pkg.sv
package pfi_pkg;

   // Fixed widths of the tag and of the count fields in a result transaction.
   localparam int TAG_BITS   = 31;
   localparam int COUNT_BITS = 7;

   // Request mode bit.
   localparam logic MODE_READOUT = 1'b1;

   typedef enum logic [1:0] {
      OUTCOME_INSERTED  = 2'd0,
      OUTCOME_DISCARDED = 2'd1,
      OUTCOME_OVERFLOW  = 2'd2,
      OUTCOME_READOUT   = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_MERGE_RD,
      ST_MERGE_EV,
      ST_MERGE_PT,
      ST_REPORT,
      ST_DUMP_RD,
      ST_DUMP_EV
   } state_type;

endpackage

FILE: rtl/core/pfi_req_if.sv
interface pfi_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [VALUE_BITS-1:0]         first_value;
   logic [VALUE_BITS-1:0]         second_value;
   logic [pfi_pkg::TAG_BITS-1:0]  tag;

   modport source (output valid, mode, first_value, second_value, tag, input ready);
   modport sink (input valid, mode, first_value, second_value, tag, output ready);
endinterface

FILE: rtl/core/pfi_rsp_if.sv
interface pfi_rsp_if #(
   parameter int VALUE_BITS = 32
);
   logic                           valid;
   logic                           ready;
   pfi_pkg::outcome_type           outcome;
   logic [pfi_pkg::COUNT_BITS-1:0] removed_count;
   logic [pfi_pkg::COUNT_BITS-1:0] frontier_count;
   logic                           entry_valid;
   logic [VALUE_BITS-1:0]          entry_first;
   logic [VALUE_BITS-1:0]          entry_second;
   logic [pfi_pkg::TAG_BITS-1:0]   entry_tag;
   logic                           last;

   modport source (
      output valid, outcome, removed_count, frontier_count, entry_valid,
             entry_first, entry_second, entry_tag, last,
      input  ready
   );
   modport sink (
      input  valid, outcome, removed_count, frontier_count, entry_valid,
             entry_first, entry_second, entry_tag, last,
      output ready
   );
endinterface

FILE: rtl/core/pareto_frontier_insert.sv
// An insert runs a scan of the frontier, then a rebuild into the other bank with an extra
// write state when the candidate lands ahead of a stored point, then the report state.
// A discard ends the scan early; an overflow goes from the scan straight to the report.
// A readout returns each stored point as its own result (one result when empty); an
// output stall holds both. One request transaction at a time: the sequencer must be idle.
// Reset is synchronous and active high; it empties the frontier, drops any pending result.
module pareto_frontier_insert #(
   parameter int MAX_POINTS = 64,
   parameter int VALUE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   pfi_req_if.sink    req_chan,
   pfi_rsp_if.source  rsp_chan
);

   // Count width holds MAX_POINTS itself; index width addresses one bank.
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int ENTRY_BITS = 2 * VALUE_BITS + pfi_pkg::TAG_BITS;
   localparam int MEM_DEPTH  = 2 << IDX_BITS;

   // The frontier lives in one of two banks of the point memory. An insert reads the
   // current bank in order and writes the surviving points, with the candidate at its
   // sorted place, into the other bank; the bank select then flips.
   logic [ENTRY_BITS-1:0] point_mem [MEM_DEPTH];

   pfi_pkg::state_type    state_ff, state_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   wr_idx_ff, wr_idx_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   removed_ff, removed_in;
   logic                  placed_ff, placed_in;
   logic                  bank_ff, bank_in;
   pfi_pkg::outcome_type  outcome_ff, outcome_in;

   logic [VALUE_BITS-1:0]        cand_first_ff, cand_second_ff;
   logic [pfi_pkg::TAG_BITS-1:0] cand_tag_ff;
   logic [ENTRY_BITS-1:0]        rd_data_ff;

   logic                           rsp_valid_ff;
   pfi_pkg::outcome_type           rsp_outcome_ff, rsp_outcome_in;
   logic [pfi_pkg::COUNT_BITS-1:0] rsp_removed_ff, rsp_removed_in;
   logic [pfi_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                           rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [VALUE_BITS-1:0]          rsp_first_ff, rsp_first_in;
   logic [VALUE_BITS-1:0]          rsp_second_ff, rsp_second_in;
   logic [pfi_pkg::TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_load;
   logic                           rsp_free;

   logic                          req_accept;
   logic                          wr_en;
   logic [IDX_BITS:0]             wr_addr;
   logic [ENTRY_BITS-1:0]         wr_data;
   logic [IDX_BITS:0]             rd_addr;
   logic [ENTRY_BITS-1:0]         cand_entry;

   logic [VALUE_BITS-1:0]        ent_first, ent_second;
   logic [pfi_pkg::TAG_BITS-1:0] ent_tag;
   logic                         ent_le_first, ent_le_second;
   logic                         cand_le_first, cand_le_second;
   logic                         ent_covers_cand, cand_covers_ent;
   logic                         idx_at_end, idx_is_last;
   logic [CNT_BITS-1:0]          idx_next;

   // The request side is open only while the sequencer is idle. A finished result
   // may still wait in the output register at that time.
   assign req_chan.ready = (state_ff == pfi_pkg::ST_IDLE) && !reset;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The read address depends on registers only, so the data of entry idx_ff is
   // present in rd_data_ff from the cycle after idx_ff settles and stays while it holds.
   assign rd_addr = {bank_ff, idx_ff[IDX_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= point_mem[rd_addr];
   end

   assign ent_first  = rd_data_ff[ENTRY_BITS-1 -: VALUE_BITS];
   assign ent_second = rd_data_ff[pfi_pkg::TAG_BITS +: VALUE_BITS];
   assign ent_tag    = rd_data_ff[pfi_pkg::TAG_BITS-1:0];
   assign cand_entry = {cand_first_ff, cand_second_ff, cand_tag_ff};

   // Shared compare unit: the stored point against the held candidate, used by
   // both the scan pass and the rebuild pass.
   assign ent_le_first    = ent_first <= cand_first_ff;
   assign ent_le_second   = ent_second <= cand_second_ff;
   assign cand_le_first   = cand_first_ff <= ent_first;
   assign cand_le_second  = cand_second_ff <= ent_second;
   assign ent_covers_cand = ent_le_first && ent_le_second;
   assign cand_covers_ent = cand_le_first && cand_le_second;

   assign idx_next    = idx_ff + CNT_BITS'(1);
   assign idx_at_end  = idx_ff == count_ff;
   assign idx_is_last = idx_next == count_ff;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pfi_pkg::ST_IDLE;
         idx_ff     <= '0;
         wr_idx_ff  <= '0;
         count_ff   <= '0;
         removed_ff <= '0;
         placed_ff  <= 1'b0;
         bank_ff    <= 1'b0;
         outcome_ff <= pfi_pkg::OUTCOME_INSERTED;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         wr_idx_ff  <= wr_idx_in;
         count_ff   <= count_in;
         removed_ff <= removed_in;
         placed_ff  <= placed_in;
         bank_ff    <= bank_in;
         outcome_ff <= outcome_in;
      end
   end

   // The candidate is captured with every accepted request transaction.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cand_first_ff  <= req_chan.first_value;
         cand_second_ff <= req_chan.second_value;
         cand_tag_ff    <= req_chan.tag;
      end
   end

   // Sequencer: next state, memory writes and loads of the output register.
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      wr_idx_in  = wr_idx_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      placed_in  = placed_ff;
      bank_in    = bank_ff;
      outcome_in = outcome_ff;

      wr_en   = 1'b0;
      wr_addr = {~bank_ff, wr_idx_ff[IDX_BITS-1:0]};
      wr_data = cand_entry;

      rsp_load           = 1'b0;
      rsp_outcome_in     = outcome_ff;
      rsp_removed_in     = '0;
      rsp_count_in       = pfi_pkg::COUNT_BITS'(count_ff);
      rsp_entry_valid_in = 1'b0;
      rsp_first_in       = '0;
      rsp_second_in      = '0;
      rsp_tag_in         = '0;
      rsp_last_in        = 1'b1;

      unique case (state_ff)
         pfi_pkg::ST_IDLE: begin
            if (req_accept) begin
               idx_in     = '0;
               wr_idx_in  = '0;
               removed_in = '0;
               placed_in  = 1'b0;
               if (req_chan.mode == pfi_pkg::MODE_READOUT) begin
                  state_in = pfi_pkg::ST_DUMP_RD;
               end else begin
                  state_in = pfi_pkg::ST_SCAN_RD;
               end
            end
         end

         // First pass: look for a stored point that covers the candidate and count
         // the stored points that the candidate covers.
         pfi_pkg::ST_SCAN_RD: begin
            if (idx_at_end) begin
               if (removed_ff == '0 && count_ff == CNT_BITS'(MAX_POINTS)) begin
                  outcome_in = pfi_pkg::OUTCOME_OVERFLOW;
                  state_in   = pfi_pkg::ST_REPORT;
               end else begin
                  idx_in   = '0;
                  state_in = pfi_pkg::ST_MERGE_RD;
               end
            end else begin
               state_in = pfi_pkg::ST_SCAN_EV;
            end
         end

         pfi_pkg::ST_SCAN_EV: begin
            if (ent_covers_cand) begin
               outcome_in = pfi_pkg::OUTCOME_DISCARDED;
               state_in   = pfi_pkg::ST_REPORT;
            end else begin
               if (cand_covers_ent) begin
                  removed_in = removed_ff + CNT_BITS'(1);
               end
               idx_in   = idx_next;
               state_in = pfi_pkg::ST_SCAN_RD;
            end
         end

         // Second pass: copy survivors into the other bank, slipping the candidate
         // in ahead of the first survivor with a larger first objective.
         pfi_pkg::ST_MERGE_RD: begin
            if (idx_at_end) begin
               if (!placed_ff) begin
                  wr_en = 1'b1;
               end
               count_in   = wr_idx_ff + CNT_BITS'(!placed_ff);
               bank_in    = ~bank_ff;
               outcome_in = pfi_pkg::OUTCOME_INSERTED;
               state_in   = pfi_pkg::ST_REPORT;
            end else begin
               state_in = pfi_pkg::ST_MERGE_EV;
            end
         end

         pfi_pkg::ST_MERGE_EV: begin
            if (cand_covers_ent) begin
               idx_in   = idx_next;
               state_in = pfi_pkg::ST_MERGE_RD;
            end else if (!placed_ff && !ent_le_first) begin
               wr_en     = 1'b1;
               wr_idx_in = wr_idx_ff + CNT_BITS'(1);
               placed_in = 1'b1;
               state_in  = pfi_pkg::ST_MERGE_PT;
            end else begin
               wr_en     = 1'b1;
               wr_data   = rd_data_ff;
               wr_idx_in = wr_idx_ff + CNT_BITS'(1);
               idx_in    = idx_next;
               state_in  = pfi_pkg::ST_MERGE_RD;
            end
         end

         // The stored point that followed the candidate; its read data still holds.
         pfi_pkg::ST_MERGE_PT: begin
            wr_en     = 1'b1;
            wr_data   = rd_data_ff;
            wr_idx_in = wr_idx_ff + CNT_BITS'(1);
            idx_in    = idx_next;
            state_in  = pfi_pkg::ST_MERGE_RD;
         end

         // Single result transaction for an insert or for an empty readout.
         pfi_pkg::ST_REPORT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (outcome_ff == pfi_pkg::OUTCOME_INSERTED) begin
                  rsp_removed_in = pfi_pkg::COUNT_BITS'(removed_ff);
               end
               state_in = pfi_pkg::ST_IDLE;
            end
         end

         pfi_pkg::ST_DUMP_RD: begin
            if (count_ff == '0) begin
               outcome_in = pfi_pkg::OUTCOME_READOUT;
               state_in   = pfi_pkg::ST_REPORT;
            end else begin
               state_in = pfi_pkg::ST_DUMP_EV;
            end
         end

         pfi_pkg::ST_DUMP_EV: begin
            if (rsp_free) begin
               rsp_load           = 1'b1;
               rsp_outcome_in     = pfi_pkg::OUTCOME_READOUT;
               rsp_entry_valid_in = 1'b1;
               rsp_first_in       = ent_first;
               rsp_second_in      = ent_second;
               rsp_tag_in         = ent_tag;
               rsp_last_in        = idx_is_last;
               idx_in             = idx_next;
               if (idx_is_last) begin
                  state_in = pfi_pkg::ST_IDLE;
               end else begin
                  state_in = pfi_pkg::ST_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = pfi_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: holds a result until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_outcome_ff     <= rsp_outcome_in;
         rsp_removed_ff     <= rsp_removed_in;
         rsp_count_ff       <= rsp_count_in;
         rsp_entry_valid_ff <= rsp_entry_valid_in;
         rsp_first_ff       <= rsp_first_in;
         rsp_second_ff      <= rsp_second_in;
         rsp_tag_ff         <= rsp_tag_in;
         rsp_last_ff        <= rsp_last_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.outcome        = rsp_outcome_ff;
   assign rsp_chan.removed_count  = rsp_removed_ff;
   assign rsp_chan.frontier_count = rsp_count_ff;
   assign rsp_chan.entry_valid    = rsp_entry_valid_ff;
   assign rsp_chan.entry_first    = rsp_first_ff;
   assign rsp_chan.entry_second   = rsp_second_ff;
   assign rsp_chan.entry_tag      = rsp_tag_ff;
   assign rsp_chan.last           = rsp_last_ff;

endmodule

FILE: rtl/core/pfi_checker.sv
module pfi_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pfi_pkg::outcome_type rsp_outcome,
   input logic                 rsp_entry_valid,
   input logic                 rsp_removed_nonzero,
   input logic                 rsp_last
);

   // A pending result is held until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // One request transaction at a time: the block closes right after accepting one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Insert outcomes are single, final and carry no entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != pfi_pkg::OUTCOME_READOUT |-> rsp_last && !rsp_entry_valid)
      else $error("insert result not final or carries an entry");

   // An empty readout entry only ever closes a readout.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == pfi_pkg::OUTCOME_READOUT && !rsp_entry_valid |-> rsp_last)
      else $error("empty readout entry not final");

   // Only a completed insert reports removed points.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_nonzero |-> rsp_outcome == pfi_pkg::OUTCOME_INSERTED)
      else $error("removed count on a non-insert result");

endmodule

bind pareto_frontier_insert pfi_checker u_pfi_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_outcome         (rsp_chan.outcome),
   .rsp_entry_valid     (rsp_chan.entry_valid),
   .rsp_removed_nonzero (|rsp_chan.removed_count),
   .rsp_last            (rsp_chan.last)
);
